FILE: hw/rtl/dcoef_pkg.sv
// ----------------------------------------------------------------------------
// dcoef_pkg
// shared types and constants for the diffusion coefficient pipeline
// ----------------------------------------------------------------------------
package dcoef_pkg;

	localparam int DW      = 32;
	localparam int FB      = 16;
	localparam int UW      = DW - 1;
	localparam int PROD_W  = DW + UW;
	localparam int SQ_W    = 2 * UW;
	localparam int SUM_W   = SQ_W + 1;
	localparam int ROOT_W  = 32;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int SQ_LAT  = ROOT_W + 1;
	localparam int Q_W     = UW;
	localparam int DIV_LAT = Q_W + 1;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [DW-1:0] sfix_t;
	typedef logic [UW-1:0] ufix_t;

	localparam ufix_t SAT_MAX = {UW{1'b1}};
	localparam ufix_t ONE_Q   = ufix_t'(1) << FB;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_TWO_DY = 3'd0,
		REG_INV_TWO_DZ = 3'd1,
		REG_VISC_BASE  = 3'd2,
		REG_VISC_SLOPE = 3'd3,
		REG_DIFF_BASE  = 3'd4,
		REG_DIFF_SLOPE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		ufix_t twice_visc;
		ufix_t visc_per_density;
		ufix_t visc_per_temp_density;
		ufix_t diff_per_temp_density;
	} result_t;

endpackage

FILE: hw/rtl/dcoef_sqrt.sv
// ----------------------------------------------------------------------------
// dcoef_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module dcoef_sqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [dcoef_pkg::RAD_W-1:0]  rad,
	output logic [dcoef_pkg::ROOT_W-1:0] root
);
	import dcoef_pkg::*;

	localparam int R = ROOT_W;

	logic [RAD_W-1:0] x_s    [0:R];
	logic [R:0]       rem_s  [0:R];
	logic [R-1:0]     root_s [0:R];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= rad;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= R; k++) begin : g_stage
		logic [R+2:0] r2;
		logic [R+2:0] trial;
		logic         ge;
		logic [R+2:0] rn;

		always_comb begin
			r2    = {rem_s[k-1], x_s[k-1][2*(R-k)+1 -: 2]};
			trial = {1'b0, root_s[k-1], 2'b01};
			ge    = (r2 >= trial);
			rn    = ge ? (r2 - trial) : r2;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= x_s[k-1];
				rem_s[k]  <= rn[R:0];
				root_s[k] <= {root_s[k-1][R-2:0], ge};
			end
		end
	end

	assign root = root_s[R];

endmodule

FILE: hw/rtl/dcoef_div.sv
// ----------------------------------------------------------------------------
// dcoef_div
// pipelined restoring divider with saturating quotient, one bit per stage
// ----------------------------------------------------------------------------
module dcoef_div #(
	parameter int NUM_W = 47,
	parameter int DEN_W = 31
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [NUM_W-1:0]         num,
	input  logic [DEN_W-1:0]         den,
	output logic [dcoef_pkg::Q_W-1:0] quo
);
	import dcoef_pkg::*;

	logic [DEN_W-1:0] rem_s [0:Q_W];
	logic [DEN_W-1:0] den_s [0:Q_W];
	logic [Q_W-1:0]   low_s [0:Q_W];
	logic [Q_W-1:0]   q_s   [0:Q_W];
	logic             sat_s [0:Q_W];
	logic [DEN_W-1:0] head;

	assign head = DEN_W'(num[NUM_W-1:Q_W]);

	// quotient overflows (or den is zero) when num >> Q_W is at least den
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= head;
			den_s[0] <= den;
			low_s[0] <= num[Q_W-1:0];
			q_s[0]   <= '0;
			sat_s[0] <= (head >= den);
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_stage
		logic [DEN_W:0] r2;
		logic           ge;
		logic [DEN_W:0] rn;

		always_comb begin
			r2 = {rem_s[k-1], low_s[k-1][Q_W-1]};
			ge = (r2 >= {1'b0, den_s[k-1]});
			rn = ge ? (r2 - {1'b0, den_s[k-1]}) : r2;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rn[DEN_W-1:0];
				den_s[k] <= den_s[k-1];
				low_s[k] <= {low_s[k-1][Q_W-2:0], 1'b0};
				q_s[k]   <= {q_s[k-1][Q_W-2:0], ge};
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	assign quo = sat_s[Q_W] ? SAT_MAX : q_s[Q_W];

endmodule

FILE: hw/rtl/gradient_dependent_diffusion_coeffs.sv
// ----------------------------------------------------------------------------
// gradient_dependent_diffusion_coeffs
// viscosity and diffusivity coefficients from neighbour gradients
// ----------------------------------------------------------------------------
// Input beats carry the y/z neighbours of the velocities and the entropy
// perturbation plus background density and temperature; every input beat
// gives one output beat with four saturated unsigned Q15.16 coefficients.
// Both data channels use valid/stall, a beat moves when valid is high and
// stall is low. Registers are written over the cfg port (index, data) whenever
// cfg_valid is high; cfg_ready is always high. Write them only while idle.
// Throughput is one beat per cycle while in_stall is low. The pipeline has 4 gradient
// stages, 33 for the bit-per-stage square root, 2 coefficient stages, 32 for the
// bit-per-stage dividers and 1 output register.
// A stalled output beat is held in the output register while the pipeline
// runs on into a one-beat skid register; in_stall rises only once that skid
// register is full, and nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults (inverse double
// spacings 1.0, bases and slopes 0).
// ----------------------------------------------------------------------------
module gradient_dependent_diffusion_coeffs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dcoef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcoef_pkg::UW-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dcoef_pkg::DW-1:0]      vy_y_plus,
	input  logic [dcoef_pkg::DW-1:0]      vy_y_minus,
	input  logic [dcoef_pkg::DW-1:0]      vz_z_plus,
	input  logic [dcoef_pkg::DW-1:0]      vz_z_minus,
	input  logic [dcoef_pkg::DW-1:0]      ent_y_plus,
	input  logic [dcoef_pkg::DW-1:0]      ent_y_minus,
	input  logic [dcoef_pkg::DW-1:0]      ent_z_plus,
	input  logic [dcoef_pkg::DW-1:0]      ent_z_minus,
	input  logic [dcoef_pkg::UW-1:0]      density,
	input  logic [dcoef_pkg::UW-1:0]      temperature,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dcoef_pkg::UW-1:0]      twice_visc,
	output logic [dcoef_pkg::UW-1:0]      visc_per_density,
	output logic [dcoef_pkg::UW-1:0]      visc_per_temp_density,
	output logic [dcoef_pkg::UW-1:0]      diff_per_temp_density
);
	import dcoef_pkg::*;

	function automatic logic [DW-1:0] abs_diff(input sfix_t a, input sfix_t b);
		logic [DW:0] d;
		logic [DW:0] m;
		d = {a[DW-1], a} - {b[DW-1], b};
		m = d[DW] ? ((DW+1)'(0) - d) : d;
		return m[DW-1:0];
	endfunction

	function automatic ufix_t grad_sat(input logic [DW-1:0] m, input ufix_t inv);
		logic [PROD_W-1:0]    p;
		logic [PROD_W-FB-1:0] sh;
		p  = PROD_W'(m) * PROD_W'(inv);
		sh = p[PROD_W-1:FB];
		return (sh > (PROD_W-FB)'(SAT_MAX)) ? SAT_MAX : sh[UW-1:0];
	endfunction

	function automatic ufix_t coeff_sat(input ufix_t base, input logic [UW+ROOT_W-1:0] p);
		logic [UW+ROOT_W-FB:0] s;
		s = (UW+ROOT_W-FB+1)'(base) + (UW+ROOT_W-FB+1)'(p[UW+ROOT_W-1:FB]);
		return (s > (UW+ROOT_W-FB+1)'(SAT_MAX)) ? SAT_MAX : s[UW-1:0];
	endfunction

	// config registers
	ufix_t inv_two_dy_q, inv_two_dz_q, visc_base_q, visc_slope_q, diff_base_q, diff_slope_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_two_dy_q <= ONE_Q;
			inv_two_dz_q <= ONE_Q;
			visc_base_q  <= '0;
			visc_slope_q <= '0;
			diff_base_q  <= '0;
			diff_slope_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INV_TWO_DY: inv_two_dy_q <= cfg_data;
				REG_INV_TWO_DZ: inv_two_dz_q <= cfg_data;
				REG_VISC_BASE:  visc_base_q  <= cfg_data;
				REG_VISC_SLOPE: visc_slope_q <= cfg_data;
				REG_DIFF_BASE:  diff_base_q  <= cfg_data;
				REG_DIFF_SLOPE: diff_slope_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advance
	logic skid_valid_q;
	logic out_valid_q;
	logic adv;

	assign adv      = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic sqv_s [0:SQ_LAT-1];
	logic dvv_s [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int i = 0; i < SQ_LAT; i++) sqv_s[i] <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) dvv_s[i] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			sqv_s[0] <= v_s4;
			for (int i = 1; i < SQ_LAT; i++) sqv_s[i] <= sqv_s[i-1];
			v_s5 <= sqv_s[SQ_LAT-1];
			v_s6 <= v_s5;
			dvv_s[0] <= v_s6;
			for (int i = 1; i < DIV_LAT; i++) dvv_s[i] <= dvv_s[i-1];
		end
	end

	// gradient stages
	logic [DW-1:0] mvy_s1, mvz_s1, msy_s1, msz_s1;
	ufix_t         rho_s1, tmp_s1;
	ufix_t         gvy_s2, gvz_s2, gsy_s2, gsz_s2, rho_s2, tmp_s2;
	logic [SQ_W-1:0] qvy_s3, qvz_s3, qsy_s3, qsz_s3;
	ufix_t         rho_s3, tmp_s3;
	logic [SUM_W-1:0] sumv_s4, sumd_s4;
	ufix_t         rho_s4, tmp_s4;
	ufix_t         rho_sq [0:SQ_LAT-1];
	ufix_t         tmp_sq [0:SQ_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			mvy_s1 <= abs_diff(sfix_t'(vy_y_plus), sfix_t'(vy_y_minus));
			mvz_s1 <= abs_diff(sfix_t'(vz_z_plus), sfix_t'(vz_z_minus));
			msy_s1 <= abs_diff(sfix_t'(ent_y_plus), sfix_t'(ent_y_minus));
			msz_s1 <= abs_diff(sfix_t'(ent_z_plus), sfix_t'(ent_z_minus));
			rho_s1 <= density;
			tmp_s1 <= temperature;

			gvy_s2 <= grad_sat(mvy_s1, inv_two_dy_q);
			gvz_s2 <= grad_sat(mvz_s1, inv_two_dz_q);
			gsy_s2 <= grad_sat(msy_s1, inv_two_dy_q);
			gsz_s2 <= grad_sat(msz_s1, inv_two_dz_q);
			rho_s2 <= rho_s1;
			tmp_s2 <= tmp_s1;

			qvy_s3 <= SQ_W'(gvy_s2) * SQ_W'(gvy_s2);
			qvz_s3 <= SQ_W'(gvz_s2) * SQ_W'(gvz_s2);
			qsy_s3 <= SQ_W'(gsy_s2) * SQ_W'(gsy_s2);
			qsz_s3 <= SQ_W'(gsz_s2) * SQ_W'(gsz_s2);
			rho_s3 <= rho_s2;
			tmp_s3 <= tmp_s2;

			sumv_s4 <= SUM_W'(qvy_s3) + SUM_W'(qvz_s3);
			sumd_s4 <= SUM_W'(qsy_s3) + SUM_W'(qsz_s3);
			rho_s4  <= rho_s3;
			tmp_s4  <= tmp_s3;

			rho_sq[0] <= rho_s4;
			tmp_sq[0] <= tmp_s4;
			for (int i = 1; i < SQ_LAT; i++) begin
				rho_sq[i] <= rho_sq[i-1];
				tmp_sq[i] <= tmp_sq[i-1];
			end
		end
	end

	// gradient magnitudes
	logic [ROOT_W-1:0] root_v, root_d;

	dcoef_sqrt u_sqrt_visc (
		.clk  (clk),
		.en   (adv),
		.rad  (RAD_W'(sumv_s4)),
		.root (root_v)
	);

	dcoef_sqrt u_sqrt_diff (
		.clk  (clk),
		.en   (adv),
		.rad  (RAD_W'(sumd_s4)),
		.root (root_d)
	);

	// coefficient stages
	logic [UW+ROOT_W-1:0] pv_s5, pd_s5;
	logic [2*UW-1:0]      trho_s5, trho_s6;
	ufix_t                rho_s5, rho_s6, visc_s6, diff_s6;
	ufix_t                tw_s [0:DIV_LAT-1];
	ufix_t                twice;

	always_ff @(posedge clk) begin
		if (adv) begin
			pv_s5   <= (UW+ROOT_W)'(visc_slope_q) * (UW+ROOT_W)'(root_v);
			pd_s5   <= (UW+ROOT_W)'(diff_slope_q) * (UW+ROOT_W)'(root_d);
			trho_s5 <= (2*UW)'(tmp_sq[SQ_LAT-1]) * (2*UW)'(rho_sq[SQ_LAT-1]);
			rho_s5  <= rho_sq[SQ_LAT-1];

			visc_s6 <= coeff_sat(visc_base_q, pv_s5);
			diff_s6 <= coeff_sat(diff_base_q, pd_s5);
			trho_s6 <= trho_s5;
			rho_s6  <= rho_s5;

			tw_s[0] <= twice;
			for (int i = 1; i < DIV_LAT; i++) tw_s[i] <= tw_s[i-1];
		end
	end

	assign twice = visc_s6[UW-1] ? SAT_MAX : {visc_s6[UW-2:0], 1'b0};

	// divisions
	ufix_t q_vd, q_vtd, q_dtd;

	dcoef_div #(.NUM_W(UW + FB), .DEN_W(UW)) u_div_vd (
		.clk (clk),
		.en  (adv),
		.num ({visc_s6, {FB{1'b0}}}),
		.den (rho_s6),
		.quo (q_vd)
	);

	dcoef_div #(.NUM_W(UW + 2*FB), .DEN_W(2*UW)) u_div_vtd (
		.clk (clk),
		.en  (adv),
		.num ({visc_s6, {(2*FB){1'b0}}}),
		.den (trho_s6),
		.quo (q_vtd)
	);

	dcoef_div #(.NUM_W(UW + 2*FB), .DEN_W(2*UW)) u_div_dtd (
		.clk (clk),
		.en  (adv),
		.num ({diff_s6, {(2*FB){1'b0}}}),
		.den (trho_s6),
		.quo (q_dtd)
	);

	// output register and skid
	result_t res, out_q, skid_q;
	logic    take_end;

	always_comb begin
		res.twice_visc            = tw_s[DIV_LAT-1];
		res.visc_per_density      = q_vd;
		res.visc_per_temp_density = q_vtd;
		res.diff_per_temp_density = q_dtd;
	end

	assign take_end = adv && dvv_s[DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_stall) begin
			if (take_end) skid_valid_q <= 1'b1;
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= take_end;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_stall) begin
			if (take_end) skid_q <= res;
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else if (take_end) begin
			out_q <= res;
		end
	end

	assign out_valid             = out_valid_q;
	assign twice_visc            = out_q.twice_visc;
	assign visc_per_density      = out_q.visc_per_density;
	assign visc_per_temp_density = out_q.visc_per_temp_density;
	assign diff_per_temp_density = out_q.diff_per_temp_density;

endmodule
